// File: hdl/tmpm_pkg.sv
package tmpm_pkg;

  localparam int unsigned MEASURE_ENTRIES = 64;
  localparam int unsigned TEMPO_ENTRIES   = 64;

  localparam int unsigned DIV_W   = 90;
  localparam int unsigned DVS_W   = 32;
  localparam int unsigned STEP_W  = 7;
  localparam int unsigned SUM_W   = 92;

  localparam logic [2:0] ACT_MEASURE = 3'd0;
  localparam logic [2:0] ACT_TEMPO   = 3'd1;
  localparam logic [2:0] ACT_QFRAC   = 3'd2;
  localparam logic [2:0] ACT_QTICK   = 3'd3;
  localparam logic [2:0] ACT_QBPM    = 3'd4;
  localparam logic [2:0] ACT_CLEAR   = 3'd5;

  localparam logic [2:0] STAT_OK       = 3'd0;
  localparam logic [2:0] STAT_INVALID  = 3'd1;
  localparam logic [2:0] STAT_ORDER    = 3'd2;
  localparam logic [2:0] STAT_FULL     = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW = 3'd4;

  localparam logic [1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [1:0] CFG_TICKS       = 2'd1;
  localparam logic [1:0] CFG_OFFSET      = 2'd2;

  localparam logic [19:0] SAMPLE_RATE_RESET = 20'd48000;
  localparam logic [15:0] TICKS_RESET       = 16'd480;
  localparam logic [23:0] MEAS_LEN_RESET    = 24'h04_0000;
  localparam logic [31:0] BPM_RESET         = 32'h0078_0000;

  localparam logic [STEP_W-1:0] STEPS_BEAT   = STEP_W'(40);
  localparam logic [STEP_W-1:0] STEPS_SAMPLE = STEP_W'(DIV_W);

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] measure;
    logic [15:0] numerator;
    logic [15:0] denominator;
    logic [23:0] tick;
    logic [23:0] measure_length;
    logic [31:0] bpm_value;
  } tmpm_in_t;

  typedef struct packed {
    logic signed [63:0] sample;
    logic [31:0]        bpm_out;
    logic [2:0]         status;
  } tmpm_out_t;

  typedef struct packed {
    logic [15:0] start;
    logic [47:0] beat;
    logic [23:0] len;
  } meas_ent_t;

  typedef struct packed {
    logic [47:0] beat;
    logic [63:0] sample;
    logic [31:0] bpm;
  } tempo_ent_t;

  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
    logic [DIV_W-1:0]  dividend;
    logic [DVS_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MEAS_CHK,
    S_MS_RD,
    S_MS_CMP,
    S_MS_BASE,
    S_DIV_BEAT,
    S_TEMPO_LAST,
    S_TS_RD,
    S_TS_CMP,
    S_MUL0,
    S_MUL1,
    S_DIV_GO,
    S_DIV_SMP,
    S_FIN,
    S_DONE
  } tmpm_state_e;

endpackage

// File: hdl/tempo_map_position_to_sample.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o   | in_data_i  (tmpm_in_t)
// out     | output    | out_valid_o/out_ready_i | out_data_o (tmpm_out_t)
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
// One transaction at a time. Queries binary-search the measure table and then the
// tempo table; tempo changes search only the measures and extend the last tempo entry.
// Both use the bit-serial divider (40 steps for the beat, 90 for the sample);
// measure changes, clears and invalid requests do not use the divider.
// Reset restores both tables at once; no clearing pass. A stalled result holds
// the output register; a new transaction is taken while it waits.
module tempo_map_position_to_sample #(
  parameter int unsigned MEASURE_ENTRIES = tmpm_pkg::MEASURE_ENTRIES,
  parameter int unsigned TEMPO_ENTRIES   = tmpm_pkg::TEMPO_ENTRIES
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  tmpm_pkg::tmpm_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output tmpm_pkg::tmpm_out_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [39:0]         cfg_data_i
);

  localparam int unsigned MAW = $clog2(MEASURE_ENTRIES);
  localparam int unsigned MCW = $clog2(MEASURE_ENTRIES + 1);
  localparam int unsigned TAW = $clog2(TEMPO_ENTRIES);
  localparam int unsigned TCW = $clog2(TEMPO_ENTRIES + 1);

  tmpm_pkg::tmpm_state_e state_q, state_d;

  logic [19:0] sr_q;
  logic [15:0] tpb_q;
  logic [39:0] off_q;

  logic [MCW-1:0] mcnt_q, mcnt_d, mlo_q, mlo_d, mhi_q, mhi_d;
  logic [TCW-1:0] tcnt_q, tcnt_d, tlo_q, tlo_d, thi_q, thi_d;
  logic [23:0]    m0len_q, m0len_d;

  tmpm_pkg::tmpm_in_t   in_q, in_d;
  tmpm_pkg::meas_ent_t  ment_q, ment_d, mrd_q, ment0, mlast, mwdata;
  tmpm_pkg::tempo_ent_t tent_q, tent_d, trd_q, tent0, tlast, twdata;
  logic                 tseg0_q, tseg0_d;

  logic [47:0] base_q, base_d, beat_q, beat_d;
  logic [23:0] dhi_q, dhi_d;
  logic [73:0] prod_q, prod_d;
  logic [tmpm_pkg::SUM_W-1:0] sum_q, sum_d;
  logic [2:0]  stat_q, stat_d;
  logic [63:0] smp_q, smp_d;
  logic [31:0] bpmo_q, bpmo_d;

  logic                out_valid_q, out_valid_d;
  tmpm_pkg::tmpm_out_t out_q, out_d;

  tmpm_pkg::meas_ent_t  mmem [MEASURE_ENTRIES];
  tmpm_pkg::tempo_ent_t tmem [TEMPO_ENTRIES];
  logic [MAW-1:0] m_raddr, m_waddr;
  logic [TAW-1:0] t_raddr, t_waddr;
  logic           m_we, t_we;

  tmpm_pkg::div_req_t div_req;
  tmpm_pkg::div_rsp_t div_rsp;

  logic [MCW:0]   msum;
  logic [MCW-1:0] mmid, mlast_idx;
  logic [TCW:0]   tsum;
  logic [TCW-1:0] tmid, tlast_idx;
  logic [25:0]    sr60;
  logic [15:0]    mdiff, mdiff_b;
  logic [39:0]    mprod, mprod_b, flen;
  logic [47:0]    sdiff;
  logic [63:0]    sbase;
  logic [tmpm_pkg::SUM_W-1:0] rnd;
  logic [75:0]    shr;

  tmpm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign msum      = {1'b0, mlo_q} + {1'b0, mhi_q};
  assign mmid      = msum[MCW:1];
  assign tsum      = {1'b0, tlo_q} + {1'b0, thi_q};
  assign tmid      = tsum[TCW:1];
  assign mlast_idx = mcnt_q - 1'b1;
  assign tlast_idx = tcnt_q - 1'b1;
  assign sr60      = {sr_q, 6'b0} - {4'b0, sr_q, 2'b0};

  assign ment0 = '{start: 16'd0, beat: 48'd0, len: m0len_q};
  assign tent0 = '{beat: 48'd0, sample: 64'd0, bpm: tmpm_pkg::BPM_RESET};
  assign mlast = (mlast_idx == '0) ? ment0 : mrd_q;
  assign tlast = (tlast_idx == '0) ? tent0 : trd_q;

  assign mdiff   = in_q.measure - mlast.start;
  assign mprod   = 40'(mdiff) * 40'(mlast.len);
  assign mdiff_b = in_q.measure - ment_q.start;
  assign mprod_b = 40'(mdiff_b) * 40'(ment_q.len);
  assign flen    = 40'(ment_q.len) * 40'(in_q.numerator);
  assign sdiff   = beat_q - tent_q.beat;
  assign sbase   = tseg0_q ? {{24{off_q[39]}}, off_q} : tent_q.sample;
  assign rnd     = sum_q + (sum_q[tmpm_pkg::SUM_W-1] ? tmpm_pkg::SUM_W'(16'h7FFF)
                                                     : tmpm_pkg::SUM_W'(16'h8000));
  assign shr     = rnd[tmpm_pkg::SUM_W-1:16];

  always_comb begin
    state_d     = state_q;
    mcnt_d      = mcnt_q;
    tcnt_d      = tcnt_q;
    mlo_d       = mlo_q;
    mhi_d       = mhi_q;
    tlo_d       = tlo_q;
    thi_d       = thi_q;
    m0len_d     = m0len_q;
    in_d        = in_q;
    ment_d      = ment_q;
    tent_d      = tent_q;
    tseg0_d     = tseg0_q;
    base_d      = base_q;
    beat_d      = beat_q;
    dhi_d       = dhi_q;
    prod_d      = prod_q;
    sum_d       = sum_q;
    stat_d      = stat_q;
    smp_d       = smp_q;
    bpmo_d      = bpmo_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    m_raddr     = mlast_idx[MAW-1:0];
    t_raddr     = tlast_idx[TAW-1:0];
    m_we        = 1'b0;
    m_waddr     = mlast_idx[MAW-1:0];
    mwdata      = mlast;
    t_we        = 1'b0;
    t_waddr     = tcnt_q[TAW-1:0];
    twdata      = '{beat: beat_q, sample: sum_q[63:0], bpm: in_q.bpm_value};
    div_req     = '{start: 1'b0, steps: tmpm_pkg::STEPS_BEAT, dividend: '0, divisor: '0};
    in_ready_o  = (state_q == tmpm_pkg::S_IDLE);

    unique case (state_q)
      tmpm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          in_d    = in_data_i;
          stat_d  = tmpm_pkg::STAT_OK;
          smp_d   = '0;
          bpmo_d  = '0;
          mlo_d   = '0;
          mhi_d   = mcnt_q;
          ment_d  = ment0;
          state_d = tmpm_pkg::S_MS_RD;
          unique case (in_data_i.action)
            tmpm_pkg::ACT_MEASURE: state_d = tmpm_pkg::S_MEAS_CHK;
            tmpm_pkg::ACT_TEMPO: begin
              if (in_data_i.denominator == '0 ||
                  in_data_i.numerator >= in_data_i.denominator ||
                  in_data_i.bpm_value == '0) begin
                stat_d  = tmpm_pkg::STAT_INVALID;
                state_d = tmpm_pkg::S_DONE;
              end
            end
            tmpm_pkg::ACT_QFRAC, tmpm_pkg::ACT_QTICK, tmpm_pkg::ACT_QBPM: ;
            tmpm_pkg::ACT_CLEAR: begin
              mcnt_d  = MCW'(1);
              tcnt_d  = TCW'(1);
              m0len_d = tmpm_pkg::MEAS_LEN_RESET;
              state_d = tmpm_pkg::S_DONE;
            end
            default: begin
              stat_d  = tmpm_pkg::STAT_INVALID;
              state_d = tmpm_pkg::S_DONE;
            end
          endcase
        end
      end
      tmpm_pkg::S_MEAS_CHK: begin
        state_d = tmpm_pkg::S_DONE;
        priority if (in_q.measure_length == '0) begin
          stat_d = tmpm_pkg::STAT_INVALID;
        end else if (in_q.measure < mlast.start) begin
          stat_d = tmpm_pkg::STAT_ORDER;
        end else if (in_q.measure == mlast.start) begin
          if (mlast_idx == '0) begin
            m0len_d = in_q.measure_length;
          end else begin
            m_we       = 1'b1;
            mwdata.len = in_q.measure_length;
          end
        end else if (mcnt_q >= MCW'(MEASURE_ENTRIES)) begin
          stat_d = tmpm_pkg::STAT_FULL;
        end else begin
          m_we    = 1'b1;
          m_waddr = mcnt_q[MAW-1:0];
          mwdata  = '{start: in_q.measure, beat: mlast.beat + 48'(mprod),
                      len: in_q.measure_length};
          mcnt_d  = mcnt_q + 1'b1;
        end
      end
      tmpm_pkg::S_MS_RD: begin
        if (mhi_q - mlo_q > MCW'(1)) begin
          m_raddr = mmid[MAW-1:0];
          state_d = tmpm_pkg::S_MS_CMP;
        end else begin
          state_d = tmpm_pkg::S_MS_BASE;
        end
      end
      tmpm_pkg::S_MS_CMP: begin
        if (mrd_q.start <= in_q.measure) begin
          mlo_d  = mmid;
          ment_d = mrd_q;
        end else begin
          mhi_d = mmid;
        end
        state_d = tmpm_pkg::S_MS_RD;
      end
      tmpm_pkg::S_MS_BASE: begin
        base_d        = ment_q.beat + 48'(mprod_b);
        div_req.start = 1'b1;
        div_req.steps = tmpm_pkg::STEPS_BEAT;
        if (in_q.action == tmpm_pkg::ACT_QTICK) begin
          div_req.dividend = {in_q.tick, 16'b0, 50'b0};
          div_req.divisor  = {16'b0, (tpb_q == '0) ? 16'd1 : tpb_q};
        end else begin
          div_req.dividend = {flen, 50'b0};
          div_req.divisor  = {16'b0, (in_q.denominator == '0) ? 16'd1 : in_q.denominator};
        end
        state_d = tmpm_pkg::S_DIV_BEAT;
      end
      tmpm_pkg::S_DIV_BEAT: begin
        if (div_rsp.done) begin
          beat_d  = base_q + 48'(div_rsp.quotient[39:0]);
          tlo_d   = '0;
          thi_d   = tcnt_q;
          tent_d  = tent0;
          tseg0_d = 1'b1;
          state_d = (in_q.action == tmpm_pkg::ACT_TEMPO) ? tmpm_pkg::S_TEMPO_LAST
                                                         : tmpm_pkg::S_TS_RD;
        end
      end
      tmpm_pkg::S_TEMPO_LAST: begin
        priority if (beat_q < tlast.beat) begin
          stat_d  = tmpm_pkg::STAT_ORDER;
          state_d = tmpm_pkg::S_DONE;
        end else if (tcnt_q >= TCW'(TEMPO_ENTRIES)) begin
          stat_d  = tmpm_pkg::STAT_FULL;
          state_d = tmpm_pkg::S_DONE;
        end else begin
          tent_d  = tlast;
          tseg0_d = (tlast_idx == '0);
          state_d = tmpm_pkg::S_MUL0;
        end
      end
      tmpm_pkg::S_TS_RD: begin
        if (thi_q - tlo_q > TCW'(1)) begin
          t_raddr = tmid[TAW-1:0];
          state_d = tmpm_pkg::S_TS_CMP;
        end else begin
          state_d = tmpm_pkg::S_MUL0;
        end
      end
      tmpm_pkg::S_TS_CMP: begin
        if (trd_q.beat <= beat_q) begin
          tlo_d   = tmid;
          tent_d  = trd_q;
          tseg0_d = 1'b0;
        end else begin
          thi_d = tmid;
        end
        state_d = tmpm_pkg::S_TS_RD;
      end
      tmpm_pkg::S_MUL0: begin
        prod_d  = 74'(50'(sdiff[23:0]) * 50'(sr60));
        dhi_d   = sdiff[47:24];
        state_d = tmpm_pkg::S_MUL1;
      end
      tmpm_pkg::S_MUL1: begin
        prod_d  = prod_q + {50'(dhi_q) * 50'(sr60), 24'b0};
        state_d = tmpm_pkg::S_DIV_GO;
      end
      tmpm_pkg::S_DIV_GO: begin
        div_req.start    = 1'b1;
        div_req.steps    = tmpm_pkg::STEPS_SAMPLE;
        div_req.dividend = {prod_q, 16'b0};
        div_req.divisor  = (tent_q.bpm == '0) ? 32'd1 : tent_q.bpm;
        state_d          = tmpm_pkg::S_DIV_SMP;
      end
      tmpm_pkg::S_DIV_SMP: begin
        if (div_rsp.done) begin
          sum_d   = {2'b0, div_rsp.quotient} + {{28{sbase[63]}}, sbase};
          state_d = tmpm_pkg::S_FIN;
        end
      end
      tmpm_pkg::S_FIN: begin
        state_d = tmpm_pkg::S_DONE;
        if (in_q.action == tmpm_pkg::ACT_TEMPO) begin
          if ((&sum_q[tmpm_pkg::SUM_W-1:63]) || !(|sum_q[tmpm_pkg::SUM_W-1:63])) begin
            t_we   = 1'b1;
            tcnt_d = tcnt_q + 1'b1;
          end else begin
            stat_d = tmpm_pkg::STAT_OVERFLOW;
          end
        end else begin
          if ((&shr[75:63]) || !(|shr[75:63])) begin
            smp_d = shr[63:0];
          end else begin
            smp_d = shr[75] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
          end
          if (in_q.action == tmpm_pkg::ACT_QBPM) begin
            bpmo_d = tent_q.bpm;
          end
        end
      end
      tmpm_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_d       = '{sample: smp_q, bpm_out: bpmo_q, status: stat_q};
          state_d     = tmpm_pkg::S_IDLE;
        end
      end
      default: state_d = tmpm_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tmpm_pkg::S_IDLE;
      mcnt_q      <= MCW'(1);
      tcnt_q      <= TCW'(1);
      m0len_q     <= tmpm_pkg::MEAS_LEN_RESET;
      out_valid_q <= 1'b0;
      sr_q        <= tmpm_pkg::SAMPLE_RATE_RESET;
      tpb_q       <= tmpm_pkg::TICKS_RESET;
      off_q       <= '0;
    end else begin
      state_q     <= state_d;
      mcnt_q      <= mcnt_d;
      tcnt_q      <= tcnt_d;
      m0len_q     <= m0len_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          tmpm_pkg::CFG_SAMPLE_RATE: sr_q  <= cfg_data_i[19:0];
          tmpm_pkg::CFG_TICKS:       tpb_q <= cfg_data_i[15:0];
          tmpm_pkg::CFG_OFFSET:      off_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mlo_q  <= mlo_d;
    mhi_q  <= mhi_d;
    tlo_q  <= tlo_d;
    thi_q  <= thi_d;
    in_q   <= in_d;
    ment_q <= ment_d;
    tent_q <= tent_d;
    tseg0_q <= tseg0_d;
    base_q <= base_d;
    beat_q <= beat_d;
    dhi_q  <= dhi_d;
    prod_q <= prod_d;
    sum_q  <= sum_d;
    stat_q <= stat_d;
    smp_q  <= smp_d;
    bpmo_q <= bpmo_d;
    out_q  <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (m_we) begin
      mmem[m_waddr] <= mwdata;
    end
    mrd_q <= mmem[m_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[t_waddr] <= twdata;
    end
    trd_q <= tmem[t_raddr];
  end

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// File: hdl/tmpm_div.sv
module tmpm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tmpm_pkg::div_req_t req_i,
  output tmpm_pkg::div_rsp_t rsp_o
);

  logic                               busy_q, busy_d;
  logic                               done_q, done_d;
  logic [tmpm_pkg::STEP_W-1:0]        cnt_q, cnt_d;
  logic [tmpm_pkg::DVS_W-1:0]         rem_q, rem_d;
  logic [tmpm_pkg::DVS_W-1:0]         dvs_q, dvs_d;
  logic [tmpm_pkg::DIV_W-1:0]         quo_q, quo_d;
  logic [tmpm_pkg::DVS_W:0]           trial;
  logic                               ge;

  always_comb begin
    trial  = {rem_q, quo_q[tmpm_pkg::DIV_W-1]};
    ge     = trial >= {1'b0, dvs_q};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (busy_q) begin
      rem_d = ge ? tmpm_pkg::DVS_W'(trial - {1'b0, dvs_q}) : trial[tmpm_pkg::DVS_W-1:0];
      quo_d = {quo_q[tmpm_pkg::DIV_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == tmpm_pkg::STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = req_i.steps;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      quo_d  = req_i.dividend;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

// File: sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    tmpm_pkg::tmpm_in_t  d;
    bit                  typed;
    tmpm_pkg::tmpm_out_t e;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_ready_o;
  tmpm_pkg::tmpm_in_t  in_data_i = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  tmpm_pkg::tmpm_out_t out_data_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [39:0]         cfg_data_i = '0;

  tempo_map_position_to_sample DUT (.*);

  always #5 clk_i = ~clk_i;

  logic [19:0] rate;
  logic [15:0] tpb;
  logic [39:0] ofs;
  logic [15:0] ms_start[tmpm_pkg::MEASURE_ENTRIES];
  logic [63:0] ms_beat[tmpm_pkg::MEASURE_ENTRIES];
  logic [23:0] ms_len[tmpm_pkg::MEASURE_ENTRIES];
  logic [63:0] tp_beat[tmpm_pkg::TEMPO_ENTRIES];
  logic [63:0] tp_smp[tmpm_pkg::TEMPO_ENTRIES];
  logic [31:0] tp_bpm[tmpm_pkg::TEMPO_ENTRIES];
  int unsigned ms_cnt, tp_cnt;

  tmpm_pkg::tmpm_out_t pending_results[$];
  int        errors = 0;
  bit        quiet = 0;
  bit        hold_req = 0;
  int        mcur = 0, tcur = 0;
  int        idle_cycles = 0;

  function automatic void clear_maps();
    for (int i = 0; i < tmpm_pkg::MEASURE_ENTRIES; i++) begin
      ms_start[i] = '0; ms_beat[i] = '0; ms_len[i] = '0;
    end
    for (int i = 0; i < tmpm_pkg::TEMPO_ENTRIES; i++) begin
      tp_beat[i] = '0; tp_smp[i] = '0; tp_bpm[i] = '0;
    end
    ms_len[0] = tmpm_pkg::MEAS_LEN_RESET;
    tp_bpm[0] = tmpm_pkg::BPM_RESET;
    ms_cnt = 1;
    tp_cnt = 1;
  endfunction

  function automatic logic [63:0] measure_origin(logic [15:0] m, output logic [23:0] len);
    int unsigned f;
    f = 0;
    for (int unsigned i = 1; i < ms_cnt; i++)
      if (ms_start[i] <= m) f = i;
    len = ms_len[f];
    return ms_beat[f] + 64'(m - ms_start[f]) * 64'(len);
  endfunction

  function automatic logic [63:0] frac_beat(logic [15:0] m, logic [15:0] n, logic [15:0] dn);
    logic [23:0] len;
    logic [63:0] b;
    b = measure_origin(m, len);
    if (dn == 0) dn = 1;
    return b + (64'(len) * 64'(n)) / 64'(dn);
  endfunction

  function automatic int unsigned segment_of(logic [63:0] beat);
    int unsigned f;
    f = 0;
    for (int unsigned i = 1; i < tp_cnt; i++)
      if (tp_beat[i] <= beat) f = i;
    return f;
  endfunction

  function automatic logic [127:0] sample_at(int unsigned seg, logic [63:0] beat);
    logic [63:0]  k, dv, base;
    logic [127:0] p;
    k = (64'(rate) * 64'd60) << 16;
    dv = 64'(tp_bpm[seg]);
    if (dv == 0) dv = 1;
    p = 128'(beat - tp_beat[seg]) * 128'(k);
    p = p / 128'(dv);
    base = (seg == 0) ? {{24{ofs[39]}}, ofs} : tp_smp[seg];
    return p + {{64{base[63]}}, base};
  endfunction

  function automatic bit fits64(logic [127:0] v);
    return (v[127:63] == '0) || (v[127:63] == '1);
  endfunction

  function automatic logic [63:0] rounded_sample(logic [63:0] beat);
    logic [127:0]        v;
    logic signed [127:0] s;
    v = sample_at(segment_of(beat), beat);
    v = v + (v[127] ? 128'h7FFF : 128'h8000);
    s = $signed(v) >>> 16;
    if (fits64(s)) return s[63:0];
    return s[127] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
  endfunction

  function automatic tmpm_pkg::tmpm_out_t map_step(tmpm_pkg::tmpm_in_t d);
    tmpm_pkg::tmpm_out_t r;
    int unsigned  last;
    logic [23:0]  len;
    logic [63:0]  beat;
    logic [127:0] v;
    logic [15:0]  t;
    r = '0;
    case (d.action)
      tmpm_pkg::ACT_MEASURE: begin
        last = ms_cnt - 1;
        if (d.measure_length == 0) r.status = tmpm_pkg::STAT_INVALID;
        else if (d.measure < ms_start[last]) r.status = tmpm_pkg::STAT_ORDER;
        else if (d.measure == ms_start[last]) ms_len[last] = d.measure_length;
        else if (ms_cnt >= tmpm_pkg::MEASURE_ENTRIES) r.status = tmpm_pkg::STAT_FULL;
        else begin
          ms_beat[ms_cnt] = measure_origin(d.measure, len);
          ms_start[ms_cnt] = d.measure;
          ms_len[ms_cnt] = d.measure_length;
          ms_cnt++;
        end
      end
      tmpm_pkg::ACT_TEMPO: begin
        last = tp_cnt - 1;
        if (d.denominator == 0 || d.numerator >= d.denominator || d.bpm_value == 0) begin
          r.status = tmpm_pkg::STAT_INVALID;
        end else begin
          beat = frac_beat(d.measure, d.numerator, d.denominator);
          if (beat < tp_beat[last]) r.status = tmpm_pkg::STAT_ORDER;
          else if (tp_cnt >= tmpm_pkg::TEMPO_ENTRIES) r.status = tmpm_pkg::STAT_FULL;
          else begin
            v = sample_at(last, beat);
            if (!fits64(v)) r.status = tmpm_pkg::STAT_OVERFLOW;
            else begin
              tp_beat[tp_cnt] = beat;
              tp_smp[tp_cnt] = v[63:0];
              tp_bpm[tp_cnt] = d.bpm_value;
              tp_cnt++;
            end
          end
        end
      end
      tmpm_pkg::ACT_QFRAC, tmpm_pkg::ACT_QBPM: begin
        beat = frac_beat(d.measure, d.numerator, d.denominator);
        r.sample = rounded_sample(beat);
        if (d.action == tmpm_pkg::ACT_QBPM) r.bpm_out = tp_bpm[segment_of(beat)];
      end
      tmpm_pkg::ACT_QTICK: begin
        t = (tpb == 0) ? 16'd1 : tpb;
        beat = measure_origin(d.measure, len) + ({40'b0, d.tick} << 16) / 64'(t);
        r.sample = rounded_sample(beat);
      end
      tmpm_pkg::ACT_CLEAR: clear_maps();
      default: r.status = tmpm_pkg::STAT_INVALID;
    endcase
    return r;
  endfunction

  function automatic tmpm_pkg::tmpm_in_t mk(logic [2:0] a, logic [15:0] m, logic [15:0] n,
                                            logic [15:0] dn, logic [23:0] tk,
                                            logic [23:0] ln, logic [31:0] b);
    tmpm_pkg::tmpm_in_t d;
    d.action = a; d.measure = m; d.numerator = n; d.denominator = dn;
    d.tick = tk; d.measure_length = ln; d.bpm_value = b;
    return d;
  endfunction

  function automatic tmpm_pkg::tmpm_out_t res(logic [63:0] s, logic [31:0] b,
                                              logic [2:0] st);
    tmpm_pkg::tmpm_out_t r;
    r.sample = s; r.bpm_out = b; r.status = st;
    return r;
  endfunction

  function automatic tmpm_pkg::tmpm_in_t next_item(int force_act);
    tmpm_pkg::tmpm_in_t d;
    logic [159:0]       raw;
    int                 r;
    bit                 noise;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d = raw[$bits(tmpm_pkg::tmpm_in_t)-1:0];
    r = (force_act >= 0) ? force_act : $urandom_range(0, 99);
    noise = ($urandom_range(0, 9) == 0);
    if (r < 25) begin
      d.action = tmpm_pkg::ACT_MEASURE;
      mcur = (mcur + $urandom_range(0, 3)) & 16'hFFFF;
      if (!noise) d.measure = 16'(mcur);
      if ($urandom_range(0, 9) != 0) d.measure_length = 24'($urandom_range(1 << 14, 8 << 16));
    end else if (r < 45) begin
      d.action = tmpm_pkg::ACT_TEMPO;
      tcur = (tcur + $urandom_range(0, 2)) & 16'hFFFF;
      if (!noise) begin
        d.measure = 16'(tcur);
        d.denominator = 16'($urandom_range(1, 16));
        d.numerator = 16'($urandom_range(0, d.denominator - 1));
      end
      if ($urandom_range(0, 7) != 0) d.bpm_value = $urandom_range(60 << 16, 240 << 16);
    end else if (r < 90) begin
      d.action = 3'($urandom_range(tmpm_pkg::ACT_QFRAC, tmpm_pkg::ACT_QBPM));
      if (!noise) begin
        d.measure = 16'($urandom_range(0, tcur + 4));
        d.denominator = 16'($urandom_range(0, 16));
        d.numerator = 16'($urandom_range(0, 20));
        d.tick = 24'($urandom_range(0, 4000));
      end
    end else if (r < 94) begin
      d.action = tmpm_pkg::ACT_CLEAR;
      mcur = 0;
      tcur = 0;
    end else begin
      d.action = 3'($urandom_range(6, 7));
    end
    return d;
  endfunction

  task automatic send(tmpm_pkg::tmpm_in_t d, bit typed, tmpm_pkg::tmpm_out_t e);
    tmpm_pkg::tmpm_out_t p;
    in_valid_i <= 1'b1;
    in_data_i <= d;
    do @(posedge clk_i); while (!in_ready_o);
    p = map_step(d);
    pending_results.insert(pending_results.size(), typed ? e : p);
  endtask

  task automatic gap();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      tmpm_pkg::CFG_SAMPLE_RATE: rate = val[19:0];
      tmpm_pkg::CFG_TICKS:       tpb = val[15:0];
      tmpm_pkg::CFG_OFFSET:      ofs = val;
      default: ;
    endcase
  endtask

  initial begin
    row_t        rows[$];
    int          n;
    logic [19:0] rv;
    logic [15:0] tv;
    logic [39:0] ov;
    bit          held;
    bit          paused;
    held = 0;
    paused = 0;
    rate = tmpm_pkg::SAMPLE_RATE_RESET;
    tpb = tmpm_pkg::TICKS_RESET;
    ofs = '0;
    clear_maps();
    rows = '{
      '{mk(tmpm_pkg::ACT_QFRAC, 0, 0, 1, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QBPM, 0, 0, 1, 0, 0, 0), 1,
        res(0, tmpm_pkg::BPM_RESET, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QTICK, 0, 0, 0, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(3'd6, 0, 0, 0, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(3'd7, 16'hFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, '1), 1,
        res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(tmpm_pkg::ACT_MEASURE, 3, 0, 0, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(tmpm_pkg::ACT_TEMPO, 1, 0, 0, 0, 0, 100), 1, res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(tmpm_pkg::ACT_TEMPO, 1, 3, 3, 0, 0, 100), 1, res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(tmpm_pkg::ACT_TEMPO, 1, 0, 2, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_INVALID)},
      '{mk(tmpm_pkg::ACT_MEASURE, 4, 0, 0, 0, 24'h03_0000, 0), 1,
        res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_MEASURE, 2, 0, 0, 0, 24'h03_0000, 0), 1,
        res(0, 0, tmpm_pkg::STAT_ORDER)},
      '{mk(tmpm_pkg::ACT_MEASURE, 4, 0, 0, 0, 24'hFFFFFF, 0), 1,
        res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_MEASURE, 16'hFFFF, 0, 0, 0, 1, 0), 1,
        res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_TEMPO, 2, 1, 2, 0, 0, '1), 0, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_TEMPO, 1, 0, 1, 0, 0, 100), 1, res(0, 0, tmpm_pkg::STAT_ORDER)},
      '{mk(tmpm_pkg::ACT_QFRAC, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0), 0,
        res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QTICK, 16'hFFFF, 0, 0, 24'hFFFFFF, 0, 0), 0,
        res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_TEMPO, 3, 1, 2, 0, 0, 1), 0, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_TEMPO, 16'hFFFF, 0, 1, 0, 0, 1), 0, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QFRAC, 16'hFFFF, 0, 1, 0, 0, 0), 0, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QBPM, 3, 1, 2, 0, 0, 0), 0, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0), 1, res(0, 0, tmpm_pkg::STAT_OK)},
      '{mk(tmpm_pkg::ACT_QBPM, 0, 0, 1, 0, 0, 0), 1,
        res(0, tmpm_pkg::BPM_RESET, tmpm_pkg::STAT_OK)}
    };
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (rows[i]) begin
      send(rows[i].d, rows[i].typed, rows[i].e);
      gap();
    end
    for (int blk = 0; blk < 6; blk++) begin
      drain();
      case (blk)
        0: begin rv = 20'hFFFFF; tv = 16'd1;     ov = 40'h80_0000_0000; end
        1: begin rv = 20'd1;     tv = 16'hFFFF;  ov = 40'h7F_FFFF_FFFF; end
        2: begin rv = 20'd0;     tv = 16'd0;     ov = 40'd0;            end
        default: begin
          rv = 20'($urandom); tv = 16'($urandom); ov = {8'($urandom), $urandom};
        end
      endcase
      write_reg(tmpm_pkg::CFG_SAMPLE_RATE, {20'b0, rv});
      write_reg(tmpm_pkg::CFG_TICKS, {24'b0, tv});
      write_reg(tmpm_pkg::CFG_OFFSET, ov);
      cfg_valid_i <= 1'b0;
      if (blk == 5) quiet = 1;
      n = 0;
      while (n < 180) begin
        if (blk == 1 && n >= 90 && !held) begin
          hold_req = 1;
          held = 1;
        end
        if (blk == 3 && n >= 90 && !paused) begin
          drain();
          paused = 1;
        end
        if ($urandom_range(0, 7) == 0) begin
          send(mk(tmpm_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0), 0, '0);
          mcur = 0;
          tcur = 0;
          repeat (70) begin
            send(next_item($urandom_range(0, 1) ? 0 : 30), 0, '0);
            gap();
          end
          n += 71;
        end else begin
          send(next_item(-1), 0, '0);
          gap();
          n++;
        end
      end
    end
    drain();
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end

  initial begin
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (3000) @(posedge clk_i);
        hold_req = 0;
      end else if (quiet || $urandom_range(0, 2) != 0) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    tmpm_pkg::tmpm_out_t e;
    if (out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: sample %0d status %0d", out_data_o.sample,
               out_data_o.status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_data_o.sample !== e.sample) begin
          $error("sample: expected %0d, actual %0d", e.sample, out_data_o.sample);
          errors++;
        end
        if (out_data_o.bpm_out !== e.bpm_out) begin
          $error("bpm_out: expected %0h, actual %0h", e.bpm_out, out_data_o.bpm_out);
          errors++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d, actual %0d", e.status, out_data_o.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= 50000) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end
endmodule

// File: sim.f
hdl/tmpm_pkg.sv
hdl/tmpm_div.sv
hdl/tempo_map_position_to_sample.sv
sim/tb.sv
